### rtl/core/icmpcs_pkg.sv
// Shared types, constants and one's-complement helpers for the ICMPv6 checksum engine.
`default_nettype none

package icmpcs_pkg;

	localparam int unsigned MAX_MESSAGE_BYTES_DEF = 65535;
	localparam int unsigned CFG_IDX_W             = 3;
	localparam int unsigned CFG_DATA_W            = 64;
	localparam int unsigned WORD_W                = 16;
	localparam int unsigned COUNT_W               = 16;
	localparam logic [7:0]  NEXT_HEADER_RESET     = 8'h3a;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_ADDR_HIGH = 3'd0,
		REG_SRC_ADDR_LOW  = 3'd1,
		REG_DST_ADDR_HIGH = 3'd2,
		REG_DST_ADDR_LOW  = 3'd3,
		REG_NEXT_HEADER   = 3'd4
	} cfg_reg_t;

	// Pseudo-header contribution, kept as folded per-register sums
	typedef struct packed {
		logic [WORD_W-1:0] src_high_sum;
		logic [WORD_W-1:0] src_low_sum;
		logic [WORD_W-1:0] dst_high_sum;
		logic [WORD_W-1:0] dst_low_sum;
		logic [7:0]        next_header;
	} pseudo_hdr_t;

	// 16-bit add with end-around carry
	function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
	                                               input logic [WORD_W-1:0] b);
		logic [WORD_W:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[WORD_W-1:0] + WORD_W'(t[WORD_W]);
	endfunction

	// One's-complement sum of the four 16-bit words of a 64-bit value
	function automatic logic [WORD_W-1:0] fold_quad(input logic [CFG_DATA_W-1:0] v);
		logic [WORD_W+1:0] s;
		logic [WORD_W:0]   x;
		s = 18'(v[63:48]) + 18'(v[47:32]) + 18'(v[31:16]) + 18'(v[15:0]);
		x = 17'(s[WORD_W-1:0]) + 17'(s[WORD_W+1:WORD_W]);
		return x[WORD_W-1:0] + WORD_W'(x[WORD_W]);
	endfunction

endpackage

`default_nettype wire

### rtl/core/icmpv6_checksum_engine.sv
// Top level of the ICMPv6 checksum engine: byte intake, running sum and result pipeline.
//
// Usage:
//   Input channel (in_valid / in_stall, payload data_byte, last_byte) takes one
//   message byte per request, in wire order; last_byte marks the final byte.
//   Bytes pair into big-endian words that feed a 16-bit end-around-carry sum.
//   Output channel (out_valid / out_stall, payload checksum, length_error)
//   carries one request per message. length_error flags a message longer
//   than MAX_MESSAGE_BYTES; checksum then reads zero.
//   Configuration: cfg_write_en / cfg_index / cfg_data write the source and
//   destination address halves (indexes 0..3) and the next-header value (4).
//   Each address half is folded to a 16-bit sum as it is written.
// Throughput: one byte per cycle while in_stall is low, back to back, including across messages.
// Result path: after the last byte is accepted, the result passes the result
//   register s1, the pseudo-header add s2 and the output register.
// Reset: clears the message state and the pipeline, addresses to zero and the
//   next-header value to 58.
// Stall: a stalled output holds its request; the pipeline fills behind it and
//   in_stall rises once a finished message cannot move on. Non-final bytes
//   are also held back then, so no byte is ever dropped.
`default_nettype none

module icmpv6_checksum_engine
	import icmpcs_pkg::*;
#(
	parameter int unsigned MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// byte input channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  last_byte,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [WORD_W-1:0]          checksum,
	output logic                       length_error,
	// configuration write port
	input  wire logic                  cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_MESSAGE_BYTES);

	pseudo_hdr_t pseudo;

	icmpcs_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pseudo       (pseudo)
	);

	// ---------------------------------------------------------------------
	// Message state
	// ---------------------------------------------------------------------
	logic [WORD_W-1:0]  sum_q;
	logic [COUNT_W-1:0] count_q;
	logic [7:0]         held_q;
	logic               odd_q;
	logic               ovf_q;

	// Pipeline stage 1: message totals captured on the last byte
	logic               valid_s1;
	logic [WORD_W-1:0]  sum_s1;
	logic [WORD_W-1:0]  tail_s1;
	logic [COUNT_W-1:0] count_s1;
	logic               ovf_s1;

	// Pipeline stage 2: raw pseudo-header total
	logic               valid_s2;
	logic [WORD_W+2:0]  total_s2;
	logic               ovf_s2;

	// Output register
	logic               out_valid_q;
	logic [WORD_W-1:0]  checksum_q;
	logic               length_error_q;

	// Handshake and flow control
	logic out_ready;
	logic adv_s2;
	logic s2_ready;
	logic adv_s1;
	logic s1_ready;
	logic in_acc;

	assign out_ready = !out_valid_q || !out_stall;
	assign adv_s2    = valid_s2 && out_ready;
	assign s2_ready  = !valid_s2 || out_ready;
	assign adv_s1    = valid_s1 && s2_ready;
	assign s1_ready  = !valid_s1 || s2_ready;
	assign in_stall  = !s1_ready;
	assign in_acc    = in_valid && !in_stall;

	// ---------------------------------------------------------------------
	// Byte intake: pair bytes, advance running sum and count
	// ---------------------------------------------------------------------
	logic               at_max;
	logic [COUNT_W-1:0] count_nxt;
	logic               ovf_nxt;
	logic [WORD_W-1:0]  sum_nxt;
	logic [WORD_W-1:0]  tail_word;

	assign at_max    = (count_q >= MAX_COUNT);
	assign count_nxt = at_max ? count_q : count_q + COUNT_W'(1);
	assign ovf_nxt   = ovf_q || at_max;
	// Second byte of a pair completes a word
	assign sum_nxt   = odd_q ? oc_add(sum_q, {held_q, data_byte}) : sum_q;
	// Odd trailing byte becomes the high byte of a zero-padded word
	assign tail_word = odd_q ? '0 : {data_byte, 8'h00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			held_q  <= '0;
			odd_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (in_acc) begin
			if (last_byte) begin
				// clear for the next message
				sum_q   <= '0;
				count_q <= '0;
				held_q  <= '0;
				odd_q   <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				sum_q   <= sum_nxt;
				count_q <= count_nxt;
				held_q  <= odd_q ? 8'h00 : data_byte;
				odd_q   <= !odd_q;
				ovf_q   <= ovf_nxt;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: capture message totals
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc && last_byte) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && last_byte) begin
			sum_s1   <= sum_nxt;
			tail_s1  <= tail_word;
			count_s1 <= count_nxt;
			ovf_s1   <= ovf_nxt;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: add pseudo-header terms as one wide total; fold afterwards
	// ---------------------------------------------------------------------
	logic [WORD_W+2:0] total_nxt;

	assign total_nxt = 19'(sum_s1) + 19'(tail_s1)
	                 + 19'(pseudo.src_high_sum) + 19'(pseudo.src_low_sum)
	                 + 19'(pseudo.dst_high_sum) + 19'(pseudo.dst_low_sum)
	                 + 19'(count_s1) + 19'(pseudo.next_header);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (adv_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			total_s2 <= total_nxt;
			ovf_s2   <= ovf_s1;
		end
	end

	// ---------------------------------------------------------------------
	// Output: fold end-around carries twice, invert, force zero on overflow
	// ---------------------------------------------------------------------
	logic [WORD_W:0]   fold1;
	logic [WORD_W-1:0] folded;

	assign fold1  = 17'(total_s2[WORD_W-1:0]) + 17'(total_s2[WORD_W+2:WORD_W]);
	assign folded = fold1[WORD_W-1:0] + WORD_W'(fold1[WORD_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			checksum_q     <= ovf_s2 ? '0 : ~folded;
			length_error_q <= ovf_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign checksum     = checksum_q;
	assign length_error = length_error_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_COUNT)
		else $error("byte count past maximum");

	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == MAX_COUNT)
		else $error("overflow flagged below maximum count");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_byte |=> !odd_q && !ovf_q && count_q == '0 && valid_s1)
		else $error("message state not cleared after last byte");

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_valid_q && out_stall)
		else $error("input stalled with room in pipeline");

	a_error_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_error |-> checksum == '0)
		else $error("checksum not zero on length error");

endmodule

`default_nettype wire

### rtl/core/icmpcs_cfg.sv
// Configuration registers, held as folded pseudo-header sums.
`default_nettype none

module icmpcs_cfg
	import icmpcs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output pseudo_hdr_t                pseudo
);

	pseudo_hdr_t       pseudo_q;
	logic [WORD_W-1:0] wr_sum;

	assign wr_sum = fold_quad(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pseudo_q.src_high_sum <= '0;
			pseudo_q.src_low_sum  <= '0;
			pseudo_q.dst_high_sum <= '0;
			pseudo_q.dst_low_sum  <= '0;
			pseudo_q.next_header  <= NEXT_HEADER_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_SRC_ADDR_HIGH: pseudo_q.src_high_sum <= wr_sum;
				REG_SRC_ADDR_LOW:  pseudo_q.src_low_sum  <= wr_sum;
				REG_DST_ADDR_HIGH: pseudo_q.dst_high_sum <= wr_sum;
				REG_DST_ADDR_LOW:  pseudo_q.dst_low_sum  <= wr_sum;
				REG_NEXT_HEADER:   pseudo_q.next_header  <= cfg_data[7:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	assign pseudo = pseudo_q;

endmodule

`default_nettype wire
